/* hdl/sfe_pkg.sv */
package sfe_pkg;

  localparam int SAMPLE_W = 16;
  localparam int DELAY_W  = 17;
  localparam int GAIN_W   = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = DELAY_W;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 17'd17640;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd16384;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_DELAY = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN  = 2'd1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
  } in_frame_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
  } out_frame_t;

endpackage

/* hdl/sfe_delay_mod.sv */
module sfe_delay_mod #(
  parameter int RING_DEPTH = 131072
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sfe_pkg::DELAY_W-1:0]   value,
  output logic                          busy,
  output logic [$clog2(RING_DEPTH)-1:0] dmod
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int VW = sfe_pkg::DELAY_W;

  // doublings of RING_DEPTH that stay below 2^VW: one compare-and-subtract each
  function automatic int mod_steps();
    longint m;
    int     n;
    m = longint'(RING_DEPTH);
    n = 0;
    while (m < (longint'(1) << VW)) begin
      m = m * 2;
      n++;
    end
    return n;
  endfunction

  localparam int NSTEP     = mod_steps();
  localparam int STEP_LAST = (NSTEP > 0) ? NSTEP - 1 : 0;
  localparam int CW        = (NSTEP > 1) ? $clog2(NSTEP) : 1;
  localparam logic [VW-1:0] RESET_MOD = VW'(int'(sfe_pkg::DELAY_RESET) % RING_DEPTH);

  logic          busy_r;
  logic [CW-1:0] step_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] sub_val;

  // RING_DEPTH shifted up by the current step
  assign sub_val = VW'(longint'(RING_DEPTH) << step_r);

  // take off the largest multiple first, one compare-and-subtract per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      rem_r  <= RESET_MOD;
    end else if (start) begin
      busy_r <= (NSTEP != 0);
      step_r <= CW'(STEP_LAST);
      rem_r  <= value;
    end else if (busy_r) begin
      if (rem_r >= sub_val) begin
        rem_r <= rem_r - sub_val;
      end
      if (step_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        step_r <= step_r - 1'b1;
      end
    end
  end

  assign busy = busy_r;
  assign dmod = AW'(rem_r);

endmodule

/* hdl/stereo_feedback_echo.sv */
// Stereo feedback echo. Each item is one stereo frame (left_in, right_in). The
// block reads its own earlier left output from delay_samples frames back in a
// ring of RING_DEPTH samples, scales it by echo_gain/65536 (rounded toward
// minus infinity) and adds it to both channels with saturation; the saturated
// left output goes back into the ring. Throughput is one item per clock when
// nothing stalls; an item taken passes through stage 1, stage 2 and the output
// register before out_valid rises. Besides out_stall, two things slow it: when
// the delay modulo RING_DEPTH is one, each frame needs the left output of the
// frame just before it, which leaves the saturating adder in the same cycle
// the multiplier wants it, so the multiply stage waits and frames cannot be
// taken every clock; and a write of delay_samples reduces the delay modulo
// RING_DEPTH by compare-and-subtract, one step per cycle with in_stall high,
// where the step count is the number of doublings of RING_DEPTH that stay
// below 2^17: none at the default depth (the new delay holds from the next
// cycle), seven at a depth of 1024. The ring needs no clearing pass after
// reset: entries not yet reached by the write position read as zero, so items
// flow from the first cycle out of reset. Gain writes hold from the next cycle.
module stereo_feedback_echo #(
  parameter int RING_DEPTH = 131072
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  sfe_pkg::in_frame_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output sfe_pkg::out_frame_t              out_data,
  input  logic                             cfg_we,
  input  logic [sfe_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [sfe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int SW = sfe_pkg::SAMPLE_W;
  localparam int GW = sfe_pkg::GAIN_W;
  localparam int PW = SW + GW + 1;
  localparam logic [AW:0]   DEPTH_W  = (AW+1)'(RING_DEPTH);
  localparam logic [AW-1:0] LAST_POS = AW'(RING_DEPTH - 1);

  function automatic logic signed [SW-1:0] sat16(input logic signed [SW+1:0] v);
    logic signed [SW-1:0] res;
    if (v > (SW+2)'(sfe_pkg::SAMPLE_MAX)) begin
      res = sfe_pkg::SAMPLE_MAX;
    end else if (v < (SW+2)'(sfe_pkg::SAMPLE_MIN)) begin
      res = sfe_pkg::SAMPLE_MIN;
    end else begin
      res = v[SW-1:0];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  logic          mod_busy;
  logic [AW-1:0] dmod;
  logic [GW-1:0] gain_r;

  sfe_delay_mod #(.RING_DEPTH(RING_DEPTH)) u_delay_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_we && (cfg_addr == sfe_pkg::CFG_DELAY)),
    .value (cfg_wdata[sfe_pkg::DELAY_W-1:0]),
    .busy  (mod_busy),
    .dmod  (dmod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= sfe_pkg::GAIN_RESET;
    end else if (cfg_we && (cfg_addr == sfe_pkg::CFG_GAIN)) begin
      gain_r <= cfg_wdata[GW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control
  // ---------------------------------------------------------------------------
  logic accept;
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic s1_go, s2_go, s2_free, out_free, hazard;

  // ring positions
  logic [AW-1:0] pos_r, pos_nxt;
  logic          wrapped_r;
  logic [AW:0]   diff;
  logic [AW-1:0] rd_addr;
  logic          rd_ok;

  // stage 1: read data back from the ring, forward, multiply
  logic signed [SW-1:0] s1_left_r, s1_right_r;
  logic [AW-1:0]        s1_rd_r, s1_pos_r;
  logic                 s1_ok_r;
  logic signed [SW-1:0] mem_q_r;
  logic signed [SW-1:0] echo_src;
  logic signed [PW-1:0] prod;

  // stage 2: add, saturate, write back
  logic signed [SW-1:0] s2_left_r, s2_right_r;
  logic [AW-1:0]        s2_pos_r;
  logic signed [SW:0]   s2_echo_r;
  logic signed [SW-1:0] lsat, rsat;

  // last two ring writes, for forwarding
  logic                 w1_valid_r, w2_valid_r;
  logic [AW-1:0]        w1_pos_r, w2_pos_r;
  logic signed [SW-1:0] w1_data_r, w2_data_r;

  sfe_pkg::out_frame_t  out_data_r;

  // a read that lands on the slot still being computed in stage 2 must wait
  assign hazard   = s2_valid_r && (s2_pos_r == s1_rd_r);
  assign out_free = !out_valid_r || !out_stall;
  assign s2_go    = s2_valid_r && out_free;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_go    = s1_valid_r && s2_free && !hazard;
  assign in_stall = mod_busy || (s1_valid_r && !s1_go);
  assign accept   = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // read address: write position minus delay, wrapped into the ring
  // ---------------------------------------------------------------------------
  always_comb begin
    diff = {1'b0, pos_r} - {1'b0, dmod};
    if (diff[AW]) begin
      rd_addr = AW'(diff + DEPTH_W);
    end else begin
      rd_addr = diff[AW-1:0];
    end
    // every slot below the write position has been claimed by an earlier item
    rd_ok   = wrapped_r || (!diff[AW] && (dmod != '0));
    pos_nxt = (pos_r == LAST_POS) ? '0 : pos_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      wrapped_r <= 1'b0;
    end else if (accept) begin
      pos_r <= pos_nxt;
      if (pos_r == LAST_POS) begin
        wrapped_r <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // ring memory: read at accept, write when stage 2 retires
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] ring_mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (s2_go) begin
      ring_mem[s2_pos_r] <= lsat;
    end
    if (accept) begin
      mem_q_r <= ring_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_left_r  <= in_data.left_in;
      s1_right_r <= in_data.right_in;
      s1_rd_r    <= rd_addr;
      s1_pos_r   <= pos_r;
      s1_ok_r    <= rd_ok;
    end
  end

  // unwritten slots read as zero; recent writes override the memory output
  always_comb begin
    if (!s1_ok_r) begin
      echo_src = '0;
    end else if (w1_valid_r && (w1_pos_r == s1_rd_r)) begin
      echo_src = w1_data_r;
    end else if (w2_valid_r && (w2_pos_r == s1_rd_r)) begin
      echo_src = w2_data_r;
    end else begin
      echo_src = mem_q_r;
    end
    prod = $signed({1'b0, gain_r}) * echo_src;
  end

  // ---------------------------------------------------------------------------
  // stage 2
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_go) begin
      s2_valid_r <= 1'b1;
    end else if (s2_go) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_left_r  <= s1_left_r;
      s2_right_r <= s1_right_r;
      s2_pos_r   <= s1_pos_r;
      // arithmetic shift by 16 floors the product of the sample and the Q0.16 gain
      s2_echo_r  <= prod[PW-1:GW];
    end
  end

  always_comb begin
    lsat = sat16((SW+2)'(s2_left_r) + (SW+2)'(s2_echo_r));
    rsat = sat16((SW+2)'(s2_right_r) + (SW+2)'(s2_echo_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_valid_r <= 1'b0;
      w2_valid_r <= 1'b0;
    end else if (s2_go) begin
      w1_valid_r <= 1'b1;
      w2_valid_r <= w1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      w1_pos_r  <= s2_pos_r;
      w1_data_r <= lsat;
      w2_pos_r  <= w1_pos_r;
      w2_data_r <= w1_data_r;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_data_r.left_out  <= lsat;
      out_data_r.right_out <= rsat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_no_accept_while_mod: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !mod_busy)
    else $error("item taken while delay reduction runs");

  a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && accept) |=>
      (pos_r == (($past(pos_r) == LAST_POS) ? '0 : $past(pos_r) + 1'b1)))
    else $error("write position did not advance by one");

  a_retire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s2_go |=> out_valid_r)
    else $error("retired item missing from output register");

  a_fwd_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (w1_valid_r && w2_valid_r) |-> (w1_pos_r != w2_pos_r))
    else $error("two latest ring writes hit the same slot");

  a_no_hazard_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |-> !(s2_valid_r && (s2_pos_r == s1_rd_r)))
    else $error("stage 1 advanced past a pending write to its slot");

endmodule
